// ===== sv/r2fft_pkg.sv =====
// shared constants, types and twiddle table for the radix-2 fft core
package r2fft_pkg;

    localparam int LOG2_MAX_POINTS = 6;
    localparam int MAX_POINTS = 1 << LOG2_MAX_POINTS;
    localparam int AW = LOG2_MAX_POINTS;
    localparam int DW = 23;
    localparam int TW_FRAC = 17;
    localparam int TWW = 19;
    localparam int PW = TWW + DW;

    localparam logic [0:0] CFG_INVERSE = 1'b0;
    localparam logic [0:0] CFG_SIZE_LOG2 = 1'b1;

    typedef logic signed [DW-1:0] word_t;

    // one butterfly request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic          go;
        logic          inverse;
        logic [4:0]    tw_idx;
    } bfly_ctl_t;

    function automatic logic [17:0] quarter_cos(input logic [4:0] t);
        logic [17:0] r;
        case (t)
            5'd0:  r = 18'd131072;
            5'd1:  r = 18'd130441;
            5'd2:  r = 18'd128553;
            5'd3:  r = 18'd125428;
            5'd4:  r = 18'd121095;
            5'd5:  r = 18'd115595;
            5'd6:  r = 18'd108982;
            5'd7:  r = 18'd101320;
            5'd8:  r = 18'd92682;
            5'd9:  r = 18'd83151;
            5'd10: r = 18'd72820;
            5'd11: r = 18'd61787;
            5'd12: r = 18'd50159;
            5'd13: r = 18'd38048;
            5'd14: r = 18'd25571;
            5'd15: r = 18'd12847;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [TWW-1:0] tw_cos(input logic [4:0] t);
        logic signed [TWW-1:0] r;
        if (t <= 5'd16) r = signed'({1'b0, quarter_cos(t)});
        else r = -signed'({1'b0, quarter_cos(5'(6'd32 - {1'b0, t}))});
        return r;
    endfunction

    function automatic logic signed [TWW-1:0] tw_sin(input logic [4:0] t);
        logic signed [TWW-1:0] r;
        if (t <= 5'd16) r = signed'({1'b0, quarter_cos(5'(5'd16 - t))});
        else r = signed'({1'b0, quarter_cos(5'(t - 5'd16))});
        return r;
    endfunction

    function automatic word_t sat23(input logic signed [DW+1:0] v);
        word_t r;
        if (v > 25'sd4194303) r = 23'sh3FFFFF;
        else if (v < -25'sd4194304) r = 23'sh400000;
        else r = v[DW-1:0];
        return r;
    endfunction

endpackage

// ===== sv/r2fft_bfly.sv =====
// shared butterfly unit: four registered products, then rounding, add and subtract
module r2fft_bfly (
    input  logic                 aclk,
    input  r2fft_pkg::bfly_ctl_t ctl,
    input  r2fft_pkg::word_t     aj_re,
    input  r2fft_pkg::word_t     aj_im,
    input  r2fft_pkg::word_t     ak_re,
    input  r2fft_pkg::word_t     ak_im,
    output r2fft_pkg::word_t     yj_re,
    output r2fft_pkg::word_t     yj_im,
    output r2fft_pkg::word_t     yk_re,
    output r2fft_pkg::word_t     yk_im
);
    logic signed [r2fft_pkg::TWW-1:0] wr, wi;
    logic signed [r2fft_pkg::PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    r2fft_pkg::word_t aj_re_reg, aj_im_reg;
    logic signed [r2fft_pkg::PW:0] sr, si;
    logic signed [r2fft_pkg::PW-r2fft_pkg::TW_FRAC:0] tr, ti;

    always_comb begin
        wr = r2fft_pkg::tw_cos(ctl.tw_idx);
        wi = r2fft_pkg::tw_sin(ctl.tw_idx);
        if (ctl.inverse) wi = -wi;
    end

    always_ff @(posedge aclk) begin
        p_rr_reg  <= r2fft_pkg::PW'(wr * ak_re);
        p_ii_reg  <= r2fft_pkg::PW'(wi * ak_im);
        p_ri_reg  <= r2fft_pkg::PW'(wr * ak_im);
        p_ir_reg  <= r2fft_pkg::PW'(wi * ak_re);
        aj_re_reg <= aj_re;
        aj_im_reg <= aj_im;
    end

    // round to nearest, ties upward
    always_comb begin
        sr = (r2fft_pkg::PW+1)'(p_rr_reg) - (r2fft_pkg::PW+1)'(p_ii_reg)
             + (r2fft_pkg::PW+1)'(1 <<< (r2fft_pkg::TW_FRAC-1));
        si = (r2fft_pkg::PW+1)'(p_ri_reg) + (r2fft_pkg::PW+1)'(p_ir_reg)
             + (r2fft_pkg::PW+1)'(1 <<< (r2fft_pkg::TW_FRAC-1));
        tr = sr[r2fft_pkg::PW:r2fft_pkg::TW_FRAC];
        ti = si[r2fft_pkg::PW:r2fft_pkg::TW_FRAC];
        yj_re = r2fft_pkg::sat23(25'(aj_re_reg) + 25'(tr));
        yj_im = r2fft_pkg::sat23(25'(aj_im_reg) + 25'(ti));
        yk_re = r2fft_pkg::sat23(25'(aj_re_reg) - 25'(tr));
        yk_im = r2fft_pkg::sat23(25'(aj_im_reg) - 25'(ti));
    end
endmodule

// ===== sv/radix2_fft_core.sv =====
// radix-2 fft core: load sequencer, butterfly scheduler, output stage
// each butterfly steps through read, multiply and write back on the one shared unit
// throughput: one sample per cycle while loading and cfg_valid is low; then each bin is read, then scaled
// reset: synchronous active low; clears the sequencer, counts, output flags and config (inverse 0, size 6)
// the working store holds no reset value; each frame load rewrites its first N entries
module radix2_fft_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_sample_real,
    input  logic signed [15:0]            s_sample_imag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [22:0]            m_bin_real,
    output logic signed [22:0]            m_bin_imag,
    output logic [5:0]                    m_bin_index,
    output logic                          m_last_bin,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [2:0]                    cfg_data
);
    localparam int AW = r2fft_pkg::AW;

    typedef enum logic [2:0] {
        ST_LOAD, ST_RD, ST_MUL, ST_WR, ST_SCALE, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic inverse_reg, inverse_next;
    logic [2:0] size_reg, size_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [2:0] stage_reg, stage_next;
    logic [AW-1:0] bf_reg, bf_next;
    logic out_valid_reg, out_valid_next;
    logic [AW-1:0] out_idx_reg, out_idx_next;
    logic out_last_reg, out_last_next;
    r2fft_pkg::word_t out_re_reg, out_im_reg;

    r2fft_pkg::word_t mem_re [r2fft_pkg::MAX_POINTS];
    r2fft_pkg::word_t mem_im [r2fft_pkg::MAX_POINTS];
    r2fft_pkg::word_t rj_re_reg, rj_im_reg, rk_re_reg, rk_im_reg;

    logic [2:0] lg;
    logic [AW:0] npts;
    logic [AW-1:0] ld_pos, half, n_in, j_addr, k_addr;
    logic [4:0] tw;
    r2fft_pkg::bfly_ctl_t ctl;
    r2fft_pkg::word_t yj_re, yj_im, yk_re, yk_im;
    logic signed [r2fft_pkg::DW:0] sc_re, sc_im;
    logic rd_pair, wr_load, wr_bfly, wr_scale, accept, out_take, cfg_take;

    always_comb begin
        lg = size_reg;
        if (lg < 3'd1) lg = 3'd1;
        if (lg > 3'(AW)) lg = 3'(AW);
        npts = (AW+1)'(1) << lg;
        for (int i = 0; i < AW; i++)
            ld_pos[i] = (i < int'(lg)) ? cnt_reg[int'(lg) - 1 - i] : 1'b0;
        half = AW'(1) << (stage_reg - 3'd1);
        // butterfly counter: low bits pick n, upper bits the group
        n_in = bf_reg & AW'(half - 1'b1);
        j_addr = ((bf_reg & ~AW'(half - 1'b1)) << 1) | n_in;
        k_addr = j_addr | half;
        tw = 5'(n_in << (3'(AW) - stage_reg));
    end

    assign s_ready = (state_reg == ST_LOAD) && !cfg_valid;
    // no register write while a bin still waits at the output
    assign cfg_ready = (state_reg == ST_LOAD) && !out_valid_reg;
    assign cfg_take = cfg_valid && cfg_ready;
    assign accept = s_valid && s_ready;
    assign out_take = m_valid && m_ready;
    assign wr_load = accept;
    assign rd_pair = (state_reg == ST_RD) || (state_reg == ST_OUT);
    assign wr_bfly = (state_reg == ST_WR);
    assign wr_scale = 1'b0;

    assign ctl.go = (state_reg == ST_RD);
    assign ctl.inverse = inverse_reg;
    assign ctl.tw_idx = tw;

    r2fft_bfly u_bfly (
        .aclk  (aclk),
        .ctl   (ctl),
        .aj_re (rj_re_reg),
        .aj_im (rj_im_reg),
        .ak_re (rk_re_reg),
        .ak_im (rk_im_reg),
        .yj_re (yj_re),
        .yj_im (yj_im),
        .yk_re (yk_re),
        .yk_im (yk_im)
    );

    // working store: read address comes from the sequencer
    logic [AW-1:0] ra_j, ra_k;
    always_comb begin
        if (state_reg == ST_RD) begin
            ra_j = j_addr;
            ra_k = k_addr;
        end else begin
            ra_j = cnt_reg[AW-1:0];
            ra_k = cnt_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_load) begin
            mem_re[ld_pos] <= r2fft_pkg::DW'(s_sample_real);
            mem_im[ld_pos] <= r2fft_pkg::DW'(s_sample_imag);
        end else if (wr_bfly) begin
            mem_re[j_addr] <= yj_re;
            mem_im[j_addr] <= yj_im;
            mem_re[k_addr] <= yk_re;
            mem_im[k_addr] <= yk_im;
        end
        if (rd_pair || wr_scale) begin
            rj_re_reg <= mem_re[ra_j];
            rj_im_reg <= mem_im[ra_j];
            rk_re_reg <= mem_re[ra_k];
            rk_im_reg <= mem_im[ra_k];
        end
    end

    // inverse scaling: (v + N/2) >>> lg
    always_comb begin
        sc_re = ((r2fft_pkg::DW+1)'(rj_re_reg)
                 + signed'((r2fft_pkg::DW+1)'(npts >> 1))) >>> lg;
        sc_im = ((r2fft_pkg::DW+1)'(rj_im_reg)
                 + signed'((r2fft_pkg::DW+1)'(npts >> 1))) >>> lg;
    end

    always_comb begin
        state_next = state_reg;
        inverse_next = inverse_reg;
        size_next = size_reg;
        cnt_next = cnt_reg;
        stage_next = stage_reg;
        bf_next = bf_reg;
        out_valid_next = out_valid_reg;
        out_idx_next = out_idx_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (cfg_take) begin
                    unique case (cfg_index)
                        r2fft_pkg::CFG_INVERSE: inverse_next = cfg_data[0];
                        r2fft_pkg::CFG_SIZE_LOG2: begin
                            size_next = cfg_data;
                            cnt_next = '0;
                        end
                        default: ;
                    endcase
                end else if (accept) begin
                    if (cnt_reg + 1'b1 >= npts) begin
                        cnt_next = '0;
                        stage_next = 3'd1;
                        bf_next = '0;
                        state_next = ST_RD;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_RD: state_next = ST_MUL;
            ST_MUL: state_next = ST_WR;
            ST_WR: begin
                state_next = ST_RD;
                if (bf_reg == AW'((npts >> 1) - 1'b1)) begin
                    bf_next = '0;
                    if (stage_reg == lg) begin
                        cnt_next = '0;
                        state_next = ST_OUT;
                    end else begin
                        stage_next = stage_reg + 3'd1;
                    end
                end else begin
                    bf_next = bf_reg + 1'b1;
                end
            end
            ST_SCALE: begin
                // read data for bin cnt-1 is now registered
                if (!out_valid_reg || out_take) begin
                    out_valid_next = 1'b1;
                    out_idx_next = AW'(cnt_reg - 1'b1);
                    out_last_next = (cnt_reg == npts);
                    if (cnt_reg == npts) state_next = ST_LOAD;
                    else state_next = ST_OUT;
                    cnt_next = (cnt_reg == npts) ? '0 : cnt_reg;
                end else if (out_take) begin
                    out_valid_next = 1'b0;
                end
            end
            ST_OUT: begin
                if (out_take) out_valid_next = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                state_next = ST_SCALE;
            end
            default: state_next = ST_LOAD;
        endcase
        if (state_reg == ST_LOAD && out_take) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            inverse_reg <= 1'b0;
            size_reg <= 3'd6;
            cnt_reg <= '0;
            stage_reg <= 3'd1;
            bf_reg <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg <= '0;
            out_last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            inverse_reg <= inverse_next;
            size_reg <= size_next;
            cnt_reg <= cnt_next;
            stage_reg <= stage_next;
            bf_reg <= bf_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg <= out_idx_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE && (!out_valid_reg || out_take)) begin
            out_re_reg <= inverse_reg ? r2fft_pkg::sat23(25'(sc_re)) : rj_re_reg;
            out_im_reg <= inverse_reg ? r2fft_pkg::sat23(25'(sc_im)) : rj_im_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_bin_real = out_re_reg;
    assign m_bin_imag = out_im_reg;
    assign m_bin_index = out_idx_reg;
    assign m_last_bin = out_last_reg;

    // no sample taken outside loading
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> state_reg == ST_LOAD) else $error("sample taken while busy");
    // last bin ends the frame
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_bin) |-> (m_bin_index == AW'(npts - 1'b1)))
        else $error("last bin index mismatch");
    // butterfly stage never beyond frame size
    a_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |-> (stage_reg <= lg && stage_reg >= 3'd1))
        else $error("stage out of range");
endmodule
